// ===== rtl/lcpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the log capture prologue/ring store.
// No dependencies; every other file of the block refers to this package.
package lcpr_pkg;

    // store geometry
    localparam int MAX_BYTES    = 32768;
    localparam int PROLOGUE_MAX = 2048;
    localparam int LINE_MAX     = 256;
    localparam int KB_LIMIT     = 32;
    localparam int KB_BYTES     = 1024;

    // derived widths
    localparam int ADDR_W  = $clog2(MAX_BYTES);
    localparam int SIZE_W  = ADDR_W + 1;
    localparam int FILL_W  = $clog2(PROLOGUE_MAX) + 1;
    localparam int KB_W    = 6;
    localparam int LEN_W   = 8;
    localparam int DATA_W  = 8;
    localparam int PADDR_W = 3;

    // register map, indexed by word
    localparam logic REG_BUFFER_KB = 1'b0;

    // command codes
    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    // input word
    typedef struct packed {
        t_func       func;
        logic [7:0]  data_byte;
        logic        line_first;
        logic [7:0]  line_len;
        logic [14:0] read_index;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic [15:0] stored_size;
        logic [11:0] prologue_bytes;
        logic        ring_wrapped;
    } t_out_word;

    // store split, fixed between configuration writes
    typedef struct packed {
        logic              on;
        logic [FILL_W-1:0] pc;
        logic [ADDR_W-1:0] rc;
    } t_geom;

    // first stage: command decoded against capture state
    typedef struct packed {
        logic              vld;
        logic              rd;
        logic              wr;
        logic              pro;
        logic [DATA_W-1:0] data;
        logic [14:0]       idx;
        logic [ADDR_W-1:0] off;
        logic [FILL_W-1:0] fill;
        logic [ADDR_W-1:0] head;
        logic              wrap;
    } t_stage;

    // second stage: memory access ready to issue
    typedef struct packed {
        logic              vld;
        logic              wr;
        logic              rd_ok;
        logic              pro;
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] off;
        logic [SIZE_W-1:0] held;
        logic [FILL_W-1:0] fill;
        logic              wrap;
    } t_mem_op;

endpackage

// ===== rtl/lcpr_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file: buffer size register and derived split.
// Depends on lcpr_pkg.
module lcpr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcpr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic                          o_cfg_wr,
    output lcpr_pkg::t_geom               o_geom
);

    logic [lcpr_pkg::KB_W-1:0]   r_kb;
    lcpr_pkg::t_geom             r_geom;
    logic                        wr_kb;
    logic [lcpr_pkg::KB_W-1:0]   kb_in;
    logic [lcpr_pkg::KB_W-1:0]   kb_sat;
    logic [lcpr_pkg::SIZE_W:0]   tot_raw;
    logic [lcpr_pkg::SIZE_W-1:0] tot;
    logic [lcpr_pkg::SIZE_W-1:0] quarter;
    logic [lcpr_pkg::SIZE_W-1:0] rc_full;
    lcpr_pkg::t_geom             n_geom;

    assign pready = 1'b1;
    assign wr_kb  = psel && penable && pwrite && pready
                    && (paddr[2] == lcpr_pkg::REG_BUFFER_KB);
    assign kb_in  = pwdata[lcpr_pkg::KB_W-1:0];

    // split of the store for the incoming size
    always_comb begin
        kb_sat  = (kb_in > lcpr_pkg::KB_W'(lcpr_pkg::KB_LIMIT)) ?
                  lcpr_pkg::KB_W'(lcpr_pkg::KB_LIMIT) : kb_in;
        tot_raw = (lcpr_pkg::SIZE_W+1)'(kb_sat) * (lcpr_pkg::SIZE_W+1)'(lcpr_pkg::KB_BYTES);
        tot     = (tot_raw > (lcpr_pkg::SIZE_W+1)'(lcpr_pkg::MAX_BYTES)) ?
                  lcpr_pkg::SIZE_W'(lcpr_pkg::MAX_BYTES) : tot_raw[lcpr_pkg::SIZE_W-1:0];
        quarter = tot >> 2;
        n_geom.on = (tot != '0);
        n_geom.pc = (quarter > lcpr_pkg::SIZE_W'(lcpr_pkg::PROLOGUE_MAX)) ?
                    lcpr_pkg::FILL_W'(lcpr_pkg::PROLOGUE_MAX) :
                    quarter[lcpr_pkg::FILL_W-1:0];
        rc_full   = tot - lcpr_pkg::SIZE_W'(n_geom.pc);
        n_geom.rc = rc_full[lcpr_pkg::ADDR_W-1:0];
    end

    // register and split
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kb   <= '0;
            r_geom <= '0;
        end else if (wr_kb) begin
            r_kb   <= kb_in;
            r_geom <= n_geom;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == lcpr_pkg::REG_BUFFER_KB) begin
            prdata[lcpr_pkg::KB_W-1:0] = r_kb;
        end
    end

    assign o_cfg_wr = wr_kb;
    assign o_geom   = r_geom;

endmodule

// ===== rtl/lcpr_ctrl.sv =====
`timescale 1ns / 1ps
// Capture state (prologue fill, freeze, ring head, wrap) and command decode.
// Depends on lcpr_pkg; feeds lcpr_addr.
module lcpr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  lcpr_pkg::t_in_word  i_cmd,
    input  logic                i_cfg_wr,
    input  lcpr_pkg::t_geom     i_geom,
    output lcpr_pkg::t_stage    o_stage
);

    logic [lcpr_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                        r_frozen, n_frozen;
    logic [lcpr_pkg::ADDR_W-1:0] r_head, n_head;
    logic                        r_wrap, n_wrap;
    logic                        r_ltp, n_ltp;
    lcpr_pkg::t_stage            r_stage, n_stage;

    logic [lcpr_pkg::LEN_W-1:0]  len_eff;
    logic                        fit;
    logic                        ltp;
    logic                        frz;
    logic                        to_pro;
    logic [lcpr_pkg::ADDR_W:0]   head_inc;
    logic                        head_end;
    logic                        idx_pro;
    logic [lcpr_pkg::ADDR_W-1:0] fill_x;

    // line routing decision
    always_comb begin
        len_eff = (i_cmd.line_len == '0) ? lcpr_pkg::LEN_W'(1) : i_cmd.line_len;
        if (len_eff > lcpr_pkg::LEN_W'(lcpr_pkg::LINE_MAX - 1)) begin
            len_eff = lcpr_pkg::LEN_W'(lcpr_pkg::LINE_MAX - 1);
        end
        fit = ({1'b0, r_fill} + (lcpr_pkg::FILL_W+1)'(len_eff)) <= {1'b0, i_geom.pc};
        ltp = r_ltp;
        frz = r_frozen;
        if (i_cmd.line_first) begin
            ltp = !r_frozen && fit;
            if (!ltp) begin
                frz = 1'b1;
            end
        end
        to_pro   = ltp && (r_fill < i_geom.pc);
        head_inc = {1'b0, r_head} + (lcpr_pkg::ADDR_W+1)'(1);
        head_end = head_inc >= {1'b0, i_geom.rc};
        fill_x   = lcpr_pkg::ADDR_W'(r_fill);
        idx_pro  = i_cmd.read_index < fill_x;
    end

    // next state and first stage word
    always_comb begin
        n_fill   = r_fill;
        n_frozen = r_frozen;
        n_head   = r_head;
        n_wrap   = r_wrap;
        n_ltp    = r_ltp;
        n_stage  = '0;
        n_stage.vld  = i_accept;
        n_stage.data = i_cmd.data_byte;
        n_stage.idx  = i_cmd.read_index;
        if (i_accept) begin
            case (i_cmd.func)
                lcpr_pkg::FUNC_APPEND: begin
                    if (i_geom.on) begin
                        n_stage.wr = 1'b1;
                        if (to_pro) begin
                            n_fill        = r_fill + lcpr_pkg::FILL_W'(1);
                            n_ltp         = 1'b1;
                            n_frozen      = frz;
                            n_stage.pro   = 1'b1;
                            n_stage.off   = fill_x;
                        end else begin
                            n_ltp       = 1'b0;
                            n_frozen    = 1'b1;
                            n_stage.pro = 1'b0;
                            n_stage.off = r_head;
                            if (head_end) begin
                                n_head = '0;
                                n_wrap = 1'b1;
                            end else begin
                                n_head = head_inc[lcpr_pkg::ADDR_W-1:0];
                            end
                        end
                    end
                end
                lcpr_pkg::FUNC_READ: begin
                    n_stage.rd  = 1'b1;
                    n_stage.pro = idx_pro;
                    n_stage.off = idx_pro ? i_cmd.read_index :
                                  (i_cmd.read_index - fill_x);
                end
                lcpr_pkg::FUNC_CLEAR: begin
                    if (i_geom.on) begin
                        n_head = '0;
                        n_wrap = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        // a size write restarts capture
        if (i_cfg_wr) begin
            n_fill   = '0;
            n_frozen = 1'b0;
            n_head   = '0;
            n_wrap   = 1'b0;
            n_ltp    = 1'b0;
        end
        n_stage.fill = n_fill;
        n_stage.head = n_head;
        n_stage.wrap = n_wrap;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_frozen <= 1'b0;
            r_head   <= '0;
            r_wrap   <= 1'b0;
            r_ltp    <= 1'b0;
            r_stage  <= '0;
        end else begin
            r_fill   <= n_fill;
            r_frozen <= n_frozen;
            r_head   <= n_head;
            r_wrap   <= n_wrap;
            r_ltp    <= n_ltp;
            r_stage  <= n_stage;
        end
    end

    assign o_stage = r_stage;

    // ring head stays inside the ring
    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_geom.on |-> (r_head < i_geom.rc))
        else $error("ring head outside ring");

    // prologue never overruns its share
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_geom.pc)
        else $error("prologue fill exceeds capacity");

    // prologue only grows between size writes
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_wr |=> (r_fill >= $past(r_fill)))
        else $error("prologue fill went down");

endmodule

// ===== rtl/lcpr_addr.sv =====
`timescale 1ns / 1ps
// Second stage: held size, read range check and ring position unrolling.
// Depends on lcpr_pkg; sits between lcpr_ctrl and lcpr_store.
module lcpr_addr (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcpr_pkg::t_geom   i_geom,
    input  lcpr_pkg::t_stage  i_stage,
    output lcpr_pkg::t_mem_op o_op
);

    lcpr_pkg::t_mem_op           r_op, n_op;
    logic [lcpr_pkg::SIZE_W-1:0] held;
    logic [lcpr_pkg::SIZE_W-1:0] sum;
    logic [lcpr_pkg::SIZE_W-1:0] adj;
    logic                        roll;

    // held size after the command and ring offset of a read
    always_comb begin
        held = lcpr_pkg::SIZE_W'(i_stage.fill)
               + (i_stage.wrap ? lcpr_pkg::SIZE_W'(i_geom.rc) :
                                 lcpr_pkg::SIZE_W'(i_stage.head));
        if (!i_geom.on) begin
            held = '0;
        end
        roll = i_stage.rd && !i_stage.pro && i_stage.wrap;
        sum  = lcpr_pkg::SIZE_W'(i_stage.off)
               + (roll ? lcpr_pkg::SIZE_W'(i_stage.head) : '0);
        adj  = sum - lcpr_pkg::SIZE_W'(i_geom.rc);

        n_op       = '0;
        n_op.vld   = i_stage.vld;
        n_op.wr    = i_stage.wr;
        n_op.rd_ok = i_stage.rd && i_geom.on
                     && (lcpr_pkg::SIZE_W'(i_stage.idx) < held);
        n_op.pro   = i_stage.pro;
        n_op.data  = i_stage.data;
        n_op.off   = (roll && (sum >= lcpr_pkg::SIZE_W'(i_geom.rc))) ?
                     adj[lcpr_pkg::ADDR_W-1:0] : sum[lcpr_pkg::ADDR_W-1:0];
        n_op.held  = held;
        n_op.fill  = i_stage.fill;
        n_op.wrap  = i_stage.wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= n_op;
        end
    end

    assign o_op = r_op;

endmodule

// ===== rtl/lcpr_store.sv =====
`timescale 1ns / 1ps
// Byte store memory with one access per cycle and the result register.
// Depends on lcpr_pkg; takes memory operations from lcpr_addr.
module lcpr_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcpr_pkg::t_geom    i_geom,
    input  lcpr_pkg::t_mem_op  i_op,
    output logic               o_strobe,
    output lcpr_pkg::t_out_word o_result
);

    logic [lcpr_pkg::DATA_W-1:0] mem [lcpr_pkg::MAX_BYTES];
    logic [lcpr_pkg::DATA_W-1:0] r_q;
    logic [lcpr_pkg::ADDR_W-1:0] addr;
    logic                        r_vld;
    logic                        r_rd_ok;
    logic [lcpr_pkg::SIZE_W-1:0] r_held;
    logic [lcpr_pkg::FILL_W-1:0] r_fill;
    logic                        r_wrap;

    // ring entries sit after the prologue share
    assign addr = i_op.pro ? i_op.off : (lcpr_pkg::ADDR_W'(i_geom.pc) + i_op.off);

    // memory port, read returns the old byte
    always_ff @(posedge i_clk) begin
        if (i_op.vld && i_op.wr) begin
            mem[addr] <= i_op.data;
        end
        r_q <= mem[addr];
    end

    // result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_vld   <= i_op.vld;
            r_rd_ok <= i_op.vld && i_op.rd_ok;
        end
    end

    // status payload
    always_ff @(posedge i_clk) begin
        r_held <= i_op.held;
        r_fill <= i_op.fill;
        r_wrap <= i_op.wrap;
    end

    always_comb begin
        o_result.read_data      = r_rd_ok ? r_q : '0;
        o_result.read_valid     = r_rd_ok;
        o_result.stored_size    = r_held;
        o_result.prologue_bytes = r_fill;
        o_result.ring_wrapped   = r_wrap;
    end

    assign o_strobe = r_vld;

endmodule

// ===== rtl/log_capture_prologue_ring.sv =====
`timescale 1ns / 1ps
// Log capture store with a frozen prologue and a rolling ring; top level.
// Depends on lcpr_pkg, lcpr_cfg, lcpr_ctrl, lcpr_addr and lcpr_store.
//
// A command word (append, read, clear) is taken every clock cycle: busy
// stays low. Each command gives exactly one result word on o_result, marked
// by o_strobe for one cycle once it has passed the decode, address and
// result registers, in command order; the receiver cannot stall, so it
// must take every word as it appears. The pipeline in front of the single
// byte store port runs command decode against the capture state, ring
// position and range check, then the store access itself. Appends and reads
// reach the store in command order, so a read always sees the bytes of
// earlier appends and never those of later ones. Writing buffer_kb restarts
// capture and must only happen while no result is pending.
module log_capture_prologue_ring (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lcpr_pkg::t_in_word            i_cmd,
    output logic                          o_strobe,
    output lcpr_pkg::t_out_word           o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcpr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic              cfg_wr;
    lcpr_pkg::t_geom   geom;
    lcpr_pkg::t_stage  stage;
    lcpr_pkg::t_mem_op op;
    logic              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    lcpr_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg_wr (cfg_wr),
        .o_geom   (geom)
    );

    // capture state and decode
    lcpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd),
        .i_cfg_wr (cfg_wr),
        .i_geom   (geom),
        .o_stage  (stage)
    );

    // address and range stage
    lcpr_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_stage (stage),
        .o_op    (op)
    );

    // byte store and result word
    lcpr_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (geom),
        .i_op     (op),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // every taken command yields one word through the decode, address and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("result word missing");

    // a valid read only comes from a non-empty store
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.read_valid) |-> (o_result.stored_size != '0))
        else $error("valid read with empty store");

endmodule

// ===== tb/sv/log_capture_prologue_ring_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for log_capture_prologue_ring: command words in, status words out.
// Depends on lcpr_pkg and the block's RTL; keeps its own model of prologue, ring and store.
module log_capture_prologue_ring_tb;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 150000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int BUSY_IDLE_PCT = 26;

    // block ports
    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    lcpr_pkg::t_in_word            i_cmd   = '0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [lcpr_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic                          busy;
    logic                          o_strobe;
    lcpr_pkg::t_out_word           o_result;
    logic [31:0]                   prdata;
    logic                          pready;

    // model of the capture state
    logic [5:0]  cfg_kb = '0;
    int unsigned pro_fill;
    int unsigned ring_head;
    logic        pro_frozen;
    logic        ring_wrap;
    logic        line_pro;
    logic [7:0]  log_bytes [lcpr_pkg::MAX_BYTES];

    // status words predicted but not yet seen
    lcpr_pkg::t_out_word awaited_status [$];
    lcpr_pkg::t_out_word due;

    int          error_count   = 0;
    int          words_checked = 0;
    int          cmds_sent     = 0;
    int          valid_reads   = 0;
    int          wrap_words    = 0;
    int          idle_pct      = BUSY_IDLE_PCT;
    int          line_left     = 0;
    int unsigned cycle_count   = 0;

    log_capture_prologue_ring dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // geometry from buffer_kb
    function automatic int unsigned capture_bytes();
        int unsigned kb;
        int unsigned b;
        kb = (cfg_kb > lcpr_pkg::KB_LIMIT) ? lcpr_pkg::KB_LIMIT : cfg_kb;
        b  = kb * lcpr_pkg::KB_BYTES;
        return (b > lcpr_pkg::MAX_BYTES) ? lcpr_pkg::MAX_BYTES : b;
    endfunction

    function automatic int unsigned prologue_span();
        int unsigned q;
        q = capture_bytes() / 4;
        return (q < lcpr_pkg::PROLOGUE_MAX) ? q : lcpr_pkg::PROLOGUE_MAX;
    endfunction

    function automatic int unsigned ring_span();
        return capture_bytes() - prologue_span();
    endfunction

    function automatic int unsigned held_bytes();
        if (capture_bytes() == 0)
            return 0;
        return pro_fill + (ring_wrap ? ring_span() : ring_head);
    endfunction

    function automatic void restart_capture();
        pro_fill   = 0;
        pro_frozen = 1'b0;
        ring_head  = 0;
        ring_wrap  = 1'b0;
        line_pro   = 1'b0;
    endfunction

    // byte into the ring, freezing the prologue
    function automatic void ring_push(logic [7:0] b);
        int unsigned rc;
        int unsigned addr;
        rc   = ring_span();
        addr = prologue_span() + ring_head;
        pro_frozen = 1'b1;
        if (rc == 0)
            return;
        if (addr < lcpr_pkg::MAX_BYTES)
            log_bytes[addr] = b;
        ring_head++;
        if (ring_head >= rc) begin
            ring_head = 0;
            ring_wrap = 1'b1;
        end
    endfunction

    // whole line to the prologue if it fits, decided on its first byte
    function automatic void append_to_store(logic [7:0] b, logic first, int unsigned len);
        int unsigned pc;
        pc = prologue_span();
        if (len == 0)
            len = 1;
        if (len > lcpr_pkg::LINE_MAX - 1)
            len = lcpr_pkg::LINE_MAX - 1;
        if (first) begin
            line_pro = !pro_frozen && (pro_fill + len <= pc);
            if (!line_pro)
                pro_frozen = 1'b1;
        end
        if (line_pro && pro_fill < pc) begin
            log_bytes[pro_fill] = b;
            pro_fill++;
        end else begin
            line_pro = 1'b0;
            ring_push(b);
        end
    endfunction

    // logical contents: prologue, then ring oldest to newest
    function automatic logic [7:0] read_from_store(input int unsigned idx, output logic ok);
        int unsigned rc;
        int unsigned pos;
        int unsigned addr;
        rc = ring_span();
        ok = 1'b0;
        if (capture_bytes() == 0 || idx >= held_bytes())
            return 8'h00;
        ok = 1'b1;
        if (idx < pro_fill)
            return log_bytes[idx];
        pos = idx - pro_fill;
        if (ring_wrap) begin
            pos += ring_head;
            if (pos >= rc)
                pos -= rc;
        end
        addr = prologue_span() + pos;
        return (addr < lcpr_pkg::MAX_BYTES) ? log_bytes[addr] : 8'h00;
    endfunction

    // one command against the model, giving its status word
    function automatic lcpr_pkg::t_out_word apply_log_word(lcpr_pkg::t_in_word w);
        lcpr_pkg::t_out_word r;
        logic                enabled;
        logic                ok;
        enabled = capture_bytes() != 0;
        r = '0;
        case (w.func)
            lcpr_pkg::FUNC_APPEND: begin
                if (enabled)
                    append_to_store(w.data_byte, w.line_first, w.line_len);
            end
            lcpr_pkg::FUNC_READ: begin
                r.read_data  = read_from_store(w.read_index, ok);
                r.read_valid = ok;
            end
            lcpr_pkg::FUNC_CLEAR: begin
                if (enabled) begin
                    ring_head = 0;
                    ring_wrap = 1'b0;
                end
            end
            default: ;
        endcase
        r.stored_size    = 16'(held_bytes());
        r.prologue_bytes = 12'(pro_fill);
        r.ring_wrapped   = ring_wrap;
        return r;
    endfunction

    function automatic lcpr_pkg::t_in_word rand_word();
        lcpr_pkg::t_in_word w;
        w.func       = lcpr_pkg::t_func'($urandom_range(0, 3));
        w.data_byte  = 8'($urandom);
        w.line_first = 1'($urandom);
        w.line_len   = 8'($urandom);
        w.read_index = 15'($urandom);
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // send one command word, idling at random first
    task automatic send_word(input lcpr_pkg::t_in_word w);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        awaited_status.push_back(apply_log_word(w));
        cmds_sent++;
    endtask

    task automatic issue_append(input logic [7:0] d, input logic first, input logic [7:0] len);
        lcpr_pkg::t_in_word w;
        w = rand_word();
        w.func       = lcpr_pkg::FUNC_APPEND;
        w.data_byte  = d;
        w.line_first = first;
        w.line_len   = len;
        send_word(w);
    endtask

    task automatic issue_read(input logic [14:0] idx);
        lcpr_pkg::t_in_word w;
        w = rand_word();
        w.func       = lcpr_pkg::FUNC_READ;
        w.read_index = idx;
        send_word(w);
    endtask

    task automatic issue_op(input lcpr_pkg::t_func f);
        lcpr_pkg::t_in_word w;
        w = rand_word();
        w.func = f;
        send_word(w);
    endtask

    // read somewhere inside the held contents, anywhere if the store is empty
    task automatic issue_read_held();
        int unsigned h;
        h = held_bytes();
        if (h == 0)
            issue_read(15'($urandom));
        else
            issue_read(15'($urandom_range(0, h - 1)));
    endtask

    // next byte of a well-formed line with random content
    task automatic issue_line_byte(input int max_len);
        int len;
        if (line_left == 0) begin
            len = $urandom_range(1, max_len);
            issue_append(8'($urandom), 1'b1, 8'(len));
            line_left = len - 1;
        end else begin
            issue_append(8'($urandom), 1'b0, 8'($urandom));
            line_left--;
        end
    endtask

    // stop sending until every status word has come back
    task automatic wait_all_results(input int settle);
        start <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // register write then read back, only while idle
    task automatic write_buffer_kb(input logic [5:0] kb);
        wait_all_results(SETTLE_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lcpr_pkg::PADDR_W'(4 * lcpr_pkg::REG_BUFFER_KB);
        pwdata  <= 32'(kb);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        cfg_kb = kb;
        restart_capture();
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== 32'(kb))
            report_mismatch($sformatf("buffer_kb read back exp %0d got %h", kb, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // fill the prologue to its exact end, then either start a new line or overrun
    task automatic fill_prologue(input logic overrun);
        int r;
        int i;
        line_left = 0;
        while (!(line_left == 0 && pro_fill + 40 >= prologue_span())) begin
            if ($urandom_range(0, 7) == 0)
                issue_read_held();
            else
                issue_line_byte(40);
        end
        r = prologue_span() - pro_fill;
        issue_append(8'($urandom), 1'b1, 8'(r));
        for (i = 1; i < r + (overrun ? 2 : 0); i++)
            issue_append(8'($urandom), 1'b0, 8'($urandom));
        if (!overrun)
            issue_append(8'($urandom), 1'b1, 8'd1);
        line_left = 0;
    endtask

    // capture off: everything is ignored, reads invalid
    task automatic test_disabled();
        write_buffer_kb(6'd0);
        issue_append(8'h3C, 1'b1, 8'd5);
        issue_read(15'd0);
        issue_op(lcpr_pkg::FUNC_CLEAR);
        issue_op(lcpr_pkg::FUNC_NOP);
    endtask

    // field extremes, zero length, line that does not fit, clear
    task automatic test_directed_edges();
        write_buffer_kb(6'd1);
        issue_read(15'd0);
        issue_append(8'h00, 1'b1, 8'd0);
        issue_append(8'hFF, 1'b1, 8'd3);
        issue_append(8'h5A, 1'b0, 8'hFF);
        issue_append(8'hA5, 1'b0, 8'h00);
        issue_read(15'd0);
        issue_read(15'd3);
        issue_read(15'd4);
        issue_op(lcpr_pkg::FUNC_NOP);
        issue_append(8'h81, 1'b1, 8'd255);
        issue_append(8'h7E, 1'b0, 8'd1);
        issue_read(15'd4);
        issue_read(15'd5);
        issue_read(15'h7FFF);
        issue_op(lcpr_pkg::FUNC_CLEAR);
        issue_read(15'd4);
        issue_read(15'd3);
        issue_append(8'h11, 1'b1, 8'd1);
        issue_read(15'd4);
    endtask

    // continuation byte with no line open goes straight to the ring
    task automatic test_stray_continuation();
        write_buffer_kb(6'd2);
        issue_append(8'hC3, 1'b0, 8'd7);
        issue_append(8'h3C, 1'b1, 8'd1);
        issue_read(15'd0);
        issue_read(15'd1);
    endtask

    // exact prologue fill, then the ring past its wrap, then clear; no idling here
    task automatic test_fill_and_wrap();
        int extra;
        idle_pct = 0;
        write_buffer_kb(6'd1);
        fill_prologue(1'b0);
        extra = 0;
        while (extra < 200) begin
            if ($urandom_range(0, 5) == 0)
                issue_read_held();
            else
                issue_line_byte(255);
            if (ring_wrap)
                extra++;
        end
        issue_op(lcpr_pkg::FUNC_CLEAR);
        repeat (40) begin
            if ($urandom_range(0, 2) == 0)
                issue_read_held();
            else
                issue_line_byte(24);
        end
        idle_pct = BUSY_IDLE_PCT;
    endtask

    // line longer than declared runs past the full prologue
    task automatic test_line_overrun();
        write_buffer_kb(6'd1);
        fill_prologue(1'b1);
        repeat (20) issue_read_held();
    endtask

    // random mix over several sizes, mostly well-formed lines
    task automatic test_random_mix();
        logic [5:0] kb_list [5];
        int         p;
        int         n;
        int         r;
        int         len;
        kb_list    = '{6'd1, 6'd63, 6'd32, 6'd3, 6'd0};
        kb_list[4] = 6'($urandom_range(0, 63));
        for (p = 0; p < 5; p++) begin
            write_buffer_kb(kb_list[p]);
            line_left = 0;
            for (n = 0; n < 80; n++) begin
                if (p == 1 && n == 40)
                    wait_all_results(0);
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    issue_line_byte(($urandom_range(0, 9) == 0) ? 255 : 24);
                end else if (r < 80) begin
                    if ($urandom_range(0, 9) == 0)
                        issue_read(15'($urandom));
                    else
                        issue_read_held();
                end else if (r < 85) begin
                    issue_op(lcpr_pkg::FUNC_CLEAR);
                end else if (r < 88) begin
                    issue_op(lcpr_pkg::FUNC_NOP);
                end else if (r < 94) begin
                    // stray continuation, abandons any open line
                    issue_append(8'($urandom), 1'b0, 8'($urandom));
                    line_left = 0;
                end else begin
                    // new line with any length, cut short at random
                    len = $urandom_range(0, 255);
                    issue_append(8'($urandom), 1'b1, 8'(len));
                    line_left = (len > 1) ? $urandom_range(0, len - 2) : 0;
                end
            end
        end
    endtask

    // status word checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (awaited_status.size() == 0) begin
                report_mismatch($sformatf("status word %h with none expected", o_result));
            end else begin
                due = awaited_status.pop_front();
                words_checked++;
                if (o_result.read_data !== due.read_data ||
                    o_result.read_valid !== due.read_valid ||
                    o_result.stored_size !== due.stored_size ||
                    o_result.prologue_bytes !== due.prologue_bytes ||
                    o_result.ring_wrapped !== due.ring_wrapped)
                    report_mismatch($sformatf(
                        {"word %0d exp data %h vld %b size %0d pro %0d wrap %b, ",
                         "got %h %b %0d %0d %b"},
                        words_checked, due.read_data, due.read_valid, due.stored_size,
                        due.prologue_bytes, due.ring_wrapped, o_result.read_data,
                        o_result.read_valid, o_result.stored_size, o_result.prologue_bytes,
                        o_result.ring_wrapped));
                if (due.read_valid)
                    valid_reads++;
                if (due.ring_wrapped)
                    wrap_words++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     awaited_status.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_disabled();
        test_directed_edges();
        test_stray_continuation();
        test_fill_and_wrap();
        test_line_overrun();
        test_random_mix();
        wait_all_results(SETTLE_CYCLES);
        $display("run: %0d commands, %0d status words checked, %0d valid reads, %0d wrapped",
                 cmds_sent, words_checked, valid_reads, wrap_words);
        $display("sizes 0/1/2/3/32 KiB and saturated 63, exact fill, overrun, wrap and clear");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== log_capture_prologue_ring.f =====
rtl/lcpr_pkg.sv
rtl/lcpr_cfg.sv
rtl/lcpr_ctrl.sv
rtl/lcpr_addr.sv
rtl/lcpr_store.sv
rtl/log_capture_prologue_ring.sv
tb/sv/log_capture_prologue_ring_tb.sv
